[sv/aphs_pkg.sv]
// Package: shared types and constants of the ATA PIO host sequencer.
package aphs_pkg;

   localparam int WORDS_PER_SECTOR = 256;
   localparam logic [23:0] POLL_LIMIT_RESET = 24'd1000000;
   localparam int MAX_RESULTS = 6;

   typedef enum logic [2:0] {
      MODE_READ     = 3'd0,
      MODE_WRITE    = 3'd1,
      MODE_IDENTIFY = 3'd2,
      MODE_REPLY    = 3'd3,
      MODE_HOSTWORD = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_PORT_READ  = 3'd0,
      KIND_BYTE_WRITE = 3'd1,
      KIND_WORD_WRITE = 3'd2,
      KIND_DATA_HOST  = 3'd3,
      KIND_WORD_REQ   = 3'd4,
      KIND_ID_STRING  = 3'd5,
      KIND_DONE       = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      RC_OK       = 3'd0,
      RC_TIMEOUT  = 3'd1,
      RC_NOTREADY = 3'd2,
      RC_INVALID  = 3'd3,
      RC_RDFAIL   = 3'd4,
      RC_WRFAIL   = 3'd5
   } code_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        channel;
      logic        drive;
      logic [27:0] block_address;
      logic [7:0]  sector_count;
      logic [15:0] bus_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [8:0]  port_address;
      logic [15:0] out_value;
      logic [7:0]  word_index;
      logic [2:0]  result_code;
      logic [63:0] sector_total;
      logic        lba48_flag;
      logic [31:0] capability_bits;
      logic        last;
   } rsp_type;

   // Compact result as built by the step logic; totals are attached at drain.
   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  offset;
      logic        use_port;
      logic [15:0] value;
      logic [7:0]  index;
      logic [2:0]  code;
      logic        id_done;
   } item_type;

   localparam logic [8:0] BASE_PRIMARY   = 9'h1F0;
   localparam logic [8:0] BASE_SECONDARY = 9'h170;
   localparam logic [7:0] CMD_IDENTIFY   = 8'hEC;
   localparam logic [7:0] CMD_READ       = 8'h20;
   localparam logic [7:0] CMD_WRITE      = 8'h30;
   localparam logic [7:0] SEL_MASTER     = 8'hE0;
   localparam logic [7:0] SEL_SLAVE_ID   = 8'hF0;

endpackage

[sv/aphs_req_if.sv]
// Interfaces: request, result and register write channels.
interface aphs_req_if;
   logic               valid;
   logic               ready;
   aphs_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface aphs_rsp_if;
   logic               valid;
   logic               ready;
   aphs_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface aphs_csr_if;
   logic        valid;
   logic        ready;
   logic [23:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/ata_pio_host_sequencer.sv]
// Top level: ATA PIO LBA28 host sequencer.
// One request is taken in a cycle and its results (one to five) leave on rsp
// at one per cycle while rsp.ready is high, and the next request is taken in
// the cycle the last result leaves. Every port read must be answered by one
// bus read reply request; reply and host-word requests that arrive when none
// is awaited, and commands while busy, give no results. The drain queue
// between step logic and the rsp port sets the rate.
module ata_pio_host_sequencer #(
   parameter int WordsPerSector = aphs_pkg::WORDS_PER_SECTOR
) (
   input  logic        clock,
   input  logic        reset,
   aphs_req_if.sink    req,
   aphs_rsp_if.source  rsp,
   aphs_csr_if.sink    csr
);
   logic [23:0] limit_ff;
   logic        fire, busy, qvalid, qlast, channel, id_lba48;
   logic [2:0]  count;
   aphs_pkg::item_type items [aphs_pkg::MAX_RESULTS];
   aphs_pkg::item_type head;
   logic [15:0] id_words [8];
   logic [8:0]  base;

   assign csr.ready = 1'b1;
   // Accept when the queue is empty or about to empty.
   assign req.ready = !busy || (qlast && rsp.ready);
   assign fire      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= aphs_pkg::POLL_LIMIT_RESET;
      else if (csr.valid) limit_ff <= csr.data;
   end

   aphs_step #(.WordsPerSector(WordsPerSector)) u_step (
      .clock, .reset, .fire, .req(req.data), .poll_limit(limit_ff),
      .count, .items, .channel, .id_words, .id_lba48
   );

   aphs_queue u_queue (
      .clock, .reset, .load(fire && count != 3'd0), .count, .items,
      .busy, .valid(qvalid), .head, .is_last(qlast), .take(rsp.ready)
   );

   // Build the outgoing result from the queue head.
   assign base = channel ? aphs_pkg::BASE_SECONDARY : aphs_pkg::BASE_PRIMARY;
   always_comb begin
      rsp.valid = qvalid;
      rsp.data.kind = head.kind;
      rsp.data.port_address = head.use_port ? base + {5'd0, head.offset} : 9'd0;
      rsp.data.out_value = head.value;
      rsp.data.word_index = head.index;
      rsp.data.result_code = head.code;
      rsp.data.sector_total = '0;
      rsp.data.lba48_flag = 1'b0;
      rsp.data.capability_bits = '0;
      rsp.data.last = qlast;
      if (head.id_done) begin
         rsp.data.sector_total = id_lba48 ?
            {id_words[7], id_words[6], id_words[5], id_words[4]} :
            {32'd0, id_words[3], id_words[2]};
         rsp.data.lba48_flag = id_lba48;
         rsp.data.capability_bits = {id_words[1], id_words[0]};
      end
   end

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy && !(qlast && rsp.ready) |-> !fire) else $error("load while draining");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.data.last && !fire |=> !rsp.valid)
      else $error("result after last");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.kind == aphs_pkg::KIND_DONE |-> rsp.data.last)
      else $error("done not last");
endmodule

[sv/aphs_queue.sv]
// Result queue: holds the compact results of one request; drains one a cycle on take.
module aphs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [2:0]          count,
   input  aphs_pkg::item_type  items [aphs_pkg::MAX_RESULTS],
   output logic                busy,
   output logic                valid,
   output aphs_pkg::item_type  head,
   output logic                is_last,
   input  logic                take
);
   aphs_pkg::item_type items_ff [aphs_pkg::MAX_RESULTS];
   aphs_pkg::item_type items_in [aphs_pkg::MAX_RESULTS];
   logic [2:0] left_ff, left_in;

   assign valid   = left_ff != 3'd0;
   assign busy    = valid;
   assign head    = items_ff[0];
   assign is_last = left_ff == 3'd1;

   // Shift headward on take; user must load only if empty or on final take; not enforced.
   always_comb begin
      items_in = items_ff;
      left_in  = left_ff;
      if (valid && take) begin
         for (int i = 0; i < aphs_pkg::MAX_RESULTS - 1; i++) items_in[i] = items_ff[i + 1];
         left_in = left_ff - 3'd1;
      end
      if (load) begin
         items_in = items;
         left_in  = count;
      end
   end

   always_ff @(posedge clock) begin
      items_ff <= items_in;
      if (reset) left_ff <= 3'd0;
      else left_ff <= left_in;
   end
endmodule

[sv/aphs_step.sv]
// Step logic: sequencer state and the results caused by one request.
module aphs_step #(
   parameter int WordsPerSector = aphs_pkg::WORDS_PER_SECTOR
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  aphs_pkg::req_type   req,
   input  logic [23:0]         poll_limit,
   output logic [2:0]          count,
   output aphs_pkg::item_type  items [aphs_pkg::MAX_RESULTS],
   output logic                channel,
   output logic [15:0]         id_words [8],
   output logic                id_lba48
);
   localparam int WcW = $clog2(WordsPerSector) + 1;

   typedef enum logic [4:0] {
      PH_IDLE, PH_SEL_WAIT1, PH_SEL_DUMMY, PH_SEL_WAIT2, PH_DRQ, PH_RDATA,
      PH_WDATA, PH_SECT_DUMMY, PH_ID_WAIT1, PH_ID_PRE, PH_ID_DRQ, PH_ID_WAIT2,
      PH_ID_CHECK, PH_ID_DATA
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [23:0] polls_ff, polls_in;
   logic [7:0]  sectors_ff, sectors_in;
   logic [WcW-1:0] wc_ff, wc_in;
   logic [1:0]  op_ff, op_in;
   logic        chan_ff, chan_in, drv_ff, drv_in;
   logic [27:0] addr_ff, addr_in;
   logic [15:0] idw_ff [8];
   logic [15:0] idw_in [8];
   logic        lba_ff, lba_in;

   logic [23:0] limit_eff, polls_dec;
   logic [WcW-1:0] wc_inc;
   logic [15:0] bv;
   logic [7:0]  idx;
   logic [2:0]  fail_code;

   assign channel  = chan_ff;
   assign id_words = idw_ff;
   assign id_lba48 = lba_ff;

   function automatic aphs_pkg::item_type mk(aphs_pkg::kind_type k, logic [3:0] off,
                                             logic up, logic [15:0] v, logic [7:0] ix,
                                             aphs_pkg::code_type c, logic idd);
      aphs_pkg::item_type r;
      r.kind = k; r.offset = off; r.use_port = up; r.value = v; r.index = ix;
      r.code = c; r.id_done = idd;
      return r;
   endfunction

   always_comb begin
      phase_type nx;
      limit_eff = (poll_limit == 24'd0) ? 24'd1 : poll_limit;
      polls_dec = polls_ff - 24'd1;
      wc_inc    = wc_ff + 1'b1;
      bv        = req.bus_value;
      idx       = wc_ff[7:0];
      fail_code = (op_ff == 2'd1) ? aphs_pkg::RC_WRFAIL : aphs_pkg::RC_RDFAIL;
      phase_in = phase_ff; polls_in = polls_ff; sectors_in = sectors_ff; wc_in = wc_ff;
      op_in = op_ff; chan_in = chan_ff; drv_in = drv_ff; addr_in = addr_ff;
      idw_in = idw_ff; lba_in = lba_ff;
      count = 3'd0;
      nx = phase_ff;
      for (int i = 0; i < aphs_pkg::MAX_RESULTS; i++)
         items[i] = mk(aphs_pkg::KIND_DONE, 4'd0, 1'b0, 16'd0, 8'd0, aphs_pkg::RC_OK, 1'b0);
      if (fire) begin
         if (req.mode <= 3'd2) begin
            if (phase_ff == PH_IDLE) begin
               op_in = req.mode[1:0]; chan_in = req.channel; drv_in = req.drive;
               addr_in = req.block_address;
               if (req.mode == aphs_pkg::MODE_IDENTIFY) begin
                  items[0] = mk(aphs_pkg::KIND_BYTE_WRITE, 4'd6, 1'b1,
                     {8'd0, req.drive ? aphs_pkg::SEL_SLAVE_ID : aphs_pkg::SEL_MASTER},
                     8'd0, aphs_pkg::RC_OK, 1'b0);
                  items[1] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                     aphs_pkg::RC_OK, 1'b0);
                  count = 3'd2; polls_in = limit_eff; phase_in = PH_ID_WAIT1;
               end else begin
                  sectors_in = req.sector_count;
                  if (req.sector_count == 8'd0) begin
                     items[0] = mk(aphs_pkg::KIND_DONE, 4'd0, 1'b0, 16'd0, 8'd0,
                        aphs_pkg::RC_INVALID, 1'b0);
                     count = 3'd1; phase_in = PH_IDLE;
                  end else begin
                     items[0] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                     count = 3'd1; polls_in = limit_eff; phase_in = PH_SEL_WAIT1;
                  end
               end
            end
         end else if (req.mode == aphs_pkg::MODE_REPLY) begin
            unique case (phase_ff)
               PH_SEL_WAIT1, PH_SEL_WAIT2, PH_ID_WAIT1: begin
                  if (bv[7]) begin
                     polls_in = polls_dec;
                     if (polls_dec == 24'd0) begin
                        items[0] = mk(aphs_pkg::KIND_DONE, 4'd0, 1'b0, 16'd0, 8'd0,
                           aphs_pkg::RC_TIMEOUT, 1'b0);
                        phase_in = PH_IDLE;
                     end else begin
                        items[0] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                           aphs_pkg::RC_OK, 1'b0);
                     end
                     count = 3'd1;
                  end else if (bv[5] || bv[0]) begin
                     items[0] = mk(aphs_pkg::KIND_DONE, 4'd0, 1'b0, 16'd0, 8'd0,
                        aphs_pkg::RC_NOTREADY, 1'b0);
                     count = 3'd1; phase_in = PH_IDLE;
                  end else if (phase_ff == PH_SEL_WAIT1) begin
                     items[0] = mk(aphs_pkg::KIND_BYTE_WRITE, 4'd6, 1'b1,
                        {8'd0, aphs_pkg::SEL_MASTER | {3'd0, drv_ff, addr_ff[27:24]}},
                        8'd0, aphs_pkg::RC_OK, 1'b0);
                     items[1] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                     count = 3'd2; phase_in = PH_SEL_DUMMY;
                  end else if (phase_ff == PH_SEL_WAIT2) begin
                     items[0] = mk(aphs_pkg::KIND_BYTE_WRITE, 4'd2, 1'b1,
                        {8'd0, sectors_ff}, 8'd0, aphs_pkg::RC_OK, 1'b0);
                     items[1] = mk(aphs_pkg::KIND_BYTE_WRITE, 4'd7, 1'b1,
                        {8'd0, (op_ff == 2'd1) ? aphs_pkg::CMD_WRITE : aphs_pkg::CMD_READ},
                        8'd0, aphs_pkg::RC_OK, 1'b0);
                     items[2] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                     count = 3'd3; polls_in = limit_eff; phase_in = PH_DRQ;
                  end else begin
                     items[0] = mk(aphs_pkg::KIND_BYTE_WRITE, 4'd7, 1'b1,
                        {8'd0, aphs_pkg::CMD_IDENTIFY}, 8'd0, aphs_pkg::RC_OK, 1'b0);
                     items[1] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                     count = 3'd2; phase_in = PH_ID_PRE;
                  end
               end
               PH_SEL_DUMMY: begin
                  items[0] = mk(aphs_pkg::KIND_BYTE_WRITE, 4'd3, 1'b1, {8'd0, addr_ff[7:0]},
                     8'd0, aphs_pkg::RC_OK, 1'b0);
                  items[1] = mk(aphs_pkg::KIND_BYTE_WRITE, 4'd4, 1'b1, {8'd0, addr_ff[15:8]},
                     8'd0, aphs_pkg::RC_OK, 1'b0);
                  items[2] = mk(aphs_pkg::KIND_BYTE_WRITE, 4'd5, 1'b1,
                     {8'd0, addr_ff[23:16]}, 8'd0, aphs_pkg::RC_OK, 1'b0);
                  items[3] = mk(aphs_pkg::KIND_BYTE_WRITE, 4'd2, 1'b1, 16'd1, 8'd0,
                     aphs_pkg::RC_OK, 1'b0);
                  items[4] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                     aphs_pkg::RC_OK, 1'b0);
                  count = 3'd5; polls_in = limit_eff; phase_in = PH_SEL_WAIT2;
               end
               PH_DRQ: begin
                  count = 3'd1;
                  if (!bv[7] && bv[3]) begin
                     wc_in = '0;
                     if (op_ff == 2'd1) begin
                        items[0] = mk(aphs_pkg::KIND_WORD_REQ, 4'd0, 1'b0, 16'd0, 8'd0,
                           aphs_pkg::RC_OK, 1'b0);
                        phase_in = PH_WDATA;
                     end else begin
                        items[0] = mk(aphs_pkg::KIND_PORT_READ, 4'd0, 1'b1, 16'd0, 8'd0,
                           aphs_pkg::RC_OK, 1'b0);
                        phase_in = PH_RDATA;
                     end
                  end else begin
                     if (!(bv[5] || bv[0])) polls_in = polls_dec;
                     if (bv[5] || bv[0] || polls_dec == 24'd0) begin
                        items[0] = mk(aphs_pkg::KIND_DONE, 4'd0, 1'b0, 16'd0, 8'd0,
                           aphs_pkg::code_type'(fail_code), 1'b0);
                        phase_in = PH_IDLE;
                     end else begin
                        items[0] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                           aphs_pkg::RC_OK, 1'b0);
                     end
                  end
               end
               PH_RDATA: begin
                  items[0] = mk(aphs_pkg::KIND_DATA_HOST, 4'd0, 1'b0, bv, 8'd0,
                     aphs_pkg::RC_OK, 1'b0);
                  wc_in = wc_inc;
                  if (wc_inc < WcW'(WordsPerSector))
                     items[1] = mk(aphs_pkg::KIND_PORT_READ, 4'd0, 1'b1, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                  else begin
                     items[1] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                     phase_in = PH_SECT_DUMMY;
                  end
                  count = 3'd2;
               end
               PH_SECT_DUMMY: begin
                  sectors_in = sectors_ff - 8'd1;
                  count = 3'd1;
                  if (sectors_ff == 8'd1) begin
                     items[0] = mk(aphs_pkg::KIND_DONE, 4'd0, 1'b0, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                     phase_in = PH_IDLE;
                  end else begin
                     items[0] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                     polls_in = limit_eff; phase_in = PH_DRQ;
                  end
               end
               PH_ID_PRE: begin
                  items[0] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                     aphs_pkg::RC_OK, 1'b0);
                  count = 3'd1; polls_in = limit_eff; phase_in = PH_ID_DRQ;
               end
               PH_ID_DRQ: begin
                  count = 3'd1;
                  items[0] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                     aphs_pkg::RC_OK, 1'b0);
                  if (bv[3]) begin
                     polls_in = limit_eff; phase_in = PH_ID_WAIT2;
                  end else if (polls_ff == 24'd0) begin
                     items[0] = mk(aphs_pkg::KIND_DONE, 4'd0, 1'b0, 16'd0, 8'd0,
                        aphs_pkg::RC_NOTREADY, 1'b0);
                     phase_in = PH_IDLE;
                  end else polls_in = polls_dec;
               end
               PH_ID_WAIT2: begin
                  items[0] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                     aphs_pkg::RC_OK, 1'b0);
                  count = 3'd1;
                  if (bv[7]) polls_in = polls_dec;
                  if (!(bv[7] && polls_dec != 24'd0)) phase_in = PH_ID_CHECK;
               end
               PH_ID_CHECK: begin
                  count = 3'd1;
                  if (bv[0]) begin
                     items[0] = mk(aphs_pkg::KIND_DONE, 4'd0, 1'b0, 16'd0, 8'd0,
                        aphs_pkg::RC_NOTREADY, 1'b0);
                     phase_in = PH_IDLE;
                  end else begin
                     wc_in = '0;
                     items[0] = mk(aphs_pkg::KIND_PORT_READ, 4'd0, 1'b1, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                     phase_in = PH_ID_DATA;
                  end
               end
               PH_ID_DATA: begin
                  nx = PH_ID_DATA;
                  if ((idx >= 8'd10 && idx <= 8'd19) || (idx >= 8'd23 && idx <= 8'd46)) begin
                     items[count] = mk(aphs_pkg::KIND_ID_STRING, 4'd0, 1'b0,
                        {bv[7:0], bv[15:8]}, idx, aphs_pkg::RC_OK, 1'b0);
                     count = count + 3'd1;
                  end
                  if (idx == 8'd0) idw_in[0] = bv;
                  else if (idx == 8'd49) idw_in[1] = bv;
                  else if (idx == 8'd60) idw_in[2] = bv;
                  else if (idx == 8'd61) idw_in[3] = bv;
                  else if (idx >= 8'd100 && idx <= 8'd103) idw_in[3'd4 + idx[1:0]] = bv;
                  else if (idx == 8'd83) lba_in = bv[10];
                  wc_in = wc_inc;
                  if (wc_inc < WcW'(WordsPerSector))
                     items[count] = mk(aphs_pkg::KIND_PORT_READ, 4'd0, 1'b1, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b0);
                  else begin
                     items[count] = mk(aphs_pkg::KIND_DONE, 4'd0, 1'b0, 16'd0, 8'd0,
                        aphs_pkg::RC_OK, 1'b1);
                     nx = PH_IDLE;
                  end
                  count = count + 3'd1;
                  phase_in = nx;
               end
               default: ;
            endcase
         end else if (req.mode == aphs_pkg::MODE_HOSTWORD && phase_ff == PH_WDATA) begin
            items[0] = mk(aphs_pkg::KIND_WORD_WRITE, 4'd0, 1'b1, bv, 8'd0,
               aphs_pkg::RC_OK, 1'b0);
            wc_in = wc_inc;
            if (wc_inc < WcW'(WordsPerSector))
               items[1] = mk(aphs_pkg::KIND_WORD_REQ, 4'd0, 1'b0, 16'd0, 8'd0,
                  aphs_pkg::RC_OK, 1'b0);
            else begin
               items[1] = mk(aphs_pkg::KIND_PORT_READ, 4'd7, 1'b1, 16'd0, 8'd0,
                  aphs_pkg::RC_OK, 1'b0);
               phase_in = PH_SECT_DUMMY;
            end
            count = 3'd2;
         end
      end
   end

   // Hold sequencer state; identify words need no reset.
   always_ff @(posedge clock) begin
      idw_ff <= idw_in;
      addr_ff <= addr_in;
      if (reset) begin
         phase_ff <= PH_IDLE; polls_ff <= '0; sectors_ff <= '0; wc_ff <= '0;
         op_ff <= '0; chan_ff <= 1'b0; drv_ff <= 1'b0; lba_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; polls_ff <= polls_in; sectors_ff <= sectors_in;
         wc_ff <= wc_in; op_ff <= op_in; chan_ff <= chan_in; drv_ff <= drv_in;
         lba_ff <= lba_in;
      end
   end
endmodule
